/* src/e2q_pkg.sv */
// e2q_pkg: types and constants shared by the euler to quaternion core
// no dependencies
`default_nettype none
package e2q_pkg;

    localparam int ANGLE_W   = 16;
    localparam int COMP_W    = 16;
    localparam int CW        = 34;   // cordic datapath width, q30 with headroom
    localparam int TRIG_W    = 18;   // q16 cosine or sine
    localparam int ATAN_N    = 24;

    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } angles_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
    } quat_t;

    // atan(2^-i) in q30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sd843314856;
                5'd1:  r = 34'sd497837829;
                5'd2:  r = 34'sd263043836;
                5'd3:  r = 34'sd133525158;
                5'd4:  r = 34'sd67021686;
                5'd5:  r = 34'sd33543515;
                5'd6:  r = 34'sd16775850;
                5'd7:  r = 34'sd8388437;
                5'd8:  r = 34'sd4194282;
                5'd9:  r = 34'sd2097149;
                5'd10: r = 34'sd1048575;
                5'd11: r = 34'sd524287;
                5'd12: r = 34'sd262143;
                5'd13: r = 34'sd131071;
                5'd14: r = 34'sd65535;
                5'd15: r = 34'sd32767;
                5'd16: r = 34'sd16383;
                5'd17: r = 34'sd8191;
                5'd18: r = 34'sd4095;
                5'd19: r = 34'sd2047;
                5'd20: r = 34'sd1023;
                5'd21: r = 34'sd511;
                5'd22: r = 34'sd255;
                5'd23: r = 34'sd127;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* src/e2q_cordic_lane.sv */
// e2q_cordic_lane: pipelined rotation cordic giving cos and sin of a half angle
// depends on e2q_pkg
`default_nettype none
module e2q_cordic_lane #(
    parameter int STAGES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
    output logic signed [e2q_pkg::TRIG_W-1:0]        cos_q16,
    output logic signed [e2q_pkg::TRIG_W-1:0]        sin_q16
);
    import e2q_pkg::*;

    localparam int N = (STAGES > ATAN_N) ? ATAN_N : STAGES;

    logic signed [CW-1:0] x_reg [N+1];
    logic signed [CW-1:0] y_reg [N+1];
    logic signed [CW-1:0] z_reg [N+1];
    logic                 flip_reg [N+1];
    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] z_next;
    logic                 flip_next;
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yr;
    logic signed [CW-1:0] cos_next;
    logic signed [CW-1:0] sin_next;

    // range reduction of the half angle by pi
    always_comb
    begin
        z_in = {{(CW-ANGLE_W-17){angle[ANGLE_W-1]}}, angle, 17'd0};
        z_next = z_in;
        flip_next = 1'b0;
        if (z_in > HALF_PI_Q30)
        begin
            z_next = z_in - PI_Q30;
            flip_next = 1'b1;
        end
        else if (z_in < -HALF_PI_Q30)
        begin
            z_next = z_in + PI_Q30;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(5'(i));
                end
            end
        end
    end

    // undo the pi shift and round to q16
    always_comb
    begin
        xr = flip_reg[N] ? -x_reg[N] : x_reg[N];
        yr = flip_reg[N] ? -y_reg[N] : y_reg[N];
        cos_next = (xr + CW'(8192)) >>> 14;
        sin_next = (yr + CW'(8192)) >>> 14;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q16 <= cos_next[TRIG_W-1:0];
            sin_q16 <= sin_next[TRIG_W-1:0];
        end
    end
endmodule
`default_nettype wire

/* src/e2q_combine.sv */
// e2q_combine: merges the three lanes into the zyx quaternion products
// depends on e2q_pkg
`default_nettype none
module e2q_combine (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [e2q_pkg::TRIG_W-1:0]   cr,
    input  wire logic signed [e2q_pkg::TRIG_W-1:0]   sr,
    input  wire logic signed [e2q_pkg::TRIG_W-1:0]   cp,
    input  wire logic signed [e2q_pkg::TRIG_W-1:0]   sp,
    input  wire logic signed [e2q_pkg::TRIG_W-1:0]   cy,
    input  wire logic signed [e2q_pkg::TRIG_W-1:0]   sy,
    output e2q_pkg::quat_t                           quat
);
    import e2q_pkg::*;

    localparam int PW = 2 * TRIG_W;
    localparam int TW = 3 * TRIG_W;

    logic signed [PW-1:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg;
    logic signed [TRIG_W-1:0] cy_reg, sy_reg;
    logic signed [TW-1:0] t_reg [8];
    logic signed [TW:0] s [4];
    logic signed [TW:0] r [4];
    logic signed [COMP_W-1:0] q [4];

    // first products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= cr * cp;
            srsp_reg <= sr * sp;
            srcp_reg <= sr * cp;
            crsp_reg <= cr * sp;
            cy_reg   <= cy;
            sy_reg   <= sy;
        end
    end

    // triple products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= crcp_reg * cy_reg;
            t_reg[1] <= srsp_reg * sy_reg;
            t_reg[2] <= srcp_reg * cy_reg;
            t_reg[3] <= crsp_reg * sy_reg;
            t_reg[4] <= crsp_reg * cy_reg;
            t_reg[5] <= srcp_reg * sy_reg;
            t_reg[6] <= crcp_reg * sy_reg;
            t_reg[7] <= srsp_reg * cy_reg;
        end
    end

    // sums, rounding to q14 and saturation
    always_comb
    begin
        s[0] = (TW+1)'(t_reg[0]) + (TW+1)'(t_reg[1]);
        s[1] = (TW+1)'(t_reg[2]) - (TW+1)'(t_reg[3]);
        s[2] = (TW+1)'(t_reg[4]) + (TW+1)'(t_reg[5]);
        s[3] = (TW+1)'(t_reg[6]) - (TW+1)'(t_reg[7]);
        for (int k = 0; k < 4; k++)
        begin
            r[k] = (s[k] + ((TW+1)'(1) <<< 33)) >>> 34;
            if (r[k] > (TW+1)'(16384))
                q[k] = 16'sd16384;
            else if (r[k] < -(TW+1)'(16384))
                q[k] = -16'sd16384;
            else
                q[k] = r[k][COMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat.quat_w <= q[0];
            quat.quat_x <= q[1];
            quat.quat_y <= q[2];
            quat.quat_z <= q[3];
        end
    end
endmodule
`default_nettype wire

/* src/euler_to_quaternion_core.sv */
// euler_to_quaternion_core: top level, three cordic lanes and the product stage
// depends on e2q_pkg, e2q_cordic_lane, e2q_combine
`default_nettype none
// Converts roll, pitch and yaw (q3.12 radians) into a zyx unit quaternion in
// q1.14. One transfer is accepted every cycle while in_stall is low; each
// result passes through the input register and the cordic pipeline in each
// angle lane, the rounding register, the two multiplier stages and the output
// register. The whole pipeline advances when the output is free, so a stall on
// the output side holds everything in place and backs up onto the input stall.
module euler_to_quaternion_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire e2q_pkg::angles_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output e2q_pkg::quat_t         out_data
);
    import e2q_pkg::*;

    localparam int N     = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;
    localparam int DEPTH = N + 5;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    logic signed [TRIG_W-1:0] cr, sr, cp, sp, cy, sy;

    // pipeline advances whenever the last stage is empty or being taken
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    e2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk(clk), .en(en), .angle(in_data.roll),
        .cos_q16(cr), .sin_q16(sr));
    e2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk(clk), .en(en), .angle(in_data.pitch),
        .cos_q16(cp), .sin_q16(sp));
    e2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk(clk), .en(en), .angle(in_data.yaw),
        .cos_q16(cy), .sin_q16(sy));

    e2q_combine u_comb (
        .clk(clk), .en(en),
        .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
        .quat(out_data));
endmodule
`default_nettype wire
